### hdl/differential_drive_odometry_macros.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent assertion shorthands used by the odometry checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

// consequent checked in the same cycle as the antecedent
`define DDO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

`endif

### hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Widths, reset values, state and command types, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CIDX_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W   = 5;
    localparam int ANG_W        = 32;
    localparam int POS_W        = 48;
    localparam int XY_W         = 33;
    localparam int DMAG_W       = COUNT_WIDTH + 32;
    localparam int MUL_A_W      = 33;
    localparam int MUL_B_W      = 32;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int RND_W        = 34;
    localparam int TL_W         = 32;
    localparam int TPT_W        = 24;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_W         = 16;

    localparam logic [TL_W-1:0]        TL_RESET      = 32'd557337;
    localparam logic [TPT_W-1:0]       TPT_RESET     = 24'd1529356;
    localparam logic signed [XY_W-1:0] CORDIC_INIT_X = 33'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_LENGTH   = 1'b0,
        REG_TURN_PER_TICK = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_DISP,
        S_CINIT,
        S_CORD,
        S_CFIN,
        S_SIN_LO,
        S_SIN_HI,
        S_COS_LO,
        S_COS_HI,
        S_TERM_Y,
        S_ADD_Y,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_HEAD,
        MUL_DISP,
        MUL_SIN_LO,
        MUL_SIN_HI,
        MUL_COS_LO,
        MUL_COS_HI
    } t_mul_op;

    typedef struct packed {
        logic              accept;
        t_mul_op           mul_op;
        logic              heading_upd;
        logic              cordic_init;
        logic              cordic_step;
        logic [CIDX_W-1:0] cordic_idx;
        logic              cordic_fin;
        logic              rnd_load;
        logic              term_load;
        logic              add_x;
        logic              add_y;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10680862;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/ddo_in_if.sv
// ----------------------------------------------------------------------------
// Odometry input channel
// Valid/ready channel carrying one sample of both wheel encoder counters.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic                     valid;
    logic                     ready;
    logic [ddo_pkg::IN_W-1:0] left_count;
    logic [ddo_pkg::IN_W-1:0] right_count;

    modport source (output valid, output left_count, output right_count, input ready);
    modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

### hdl/ddo_out_if.sv
// ----------------------------------------------------------------------------
// Odometry output channel
// Valid/ready channel carrying position and heading.
// ----------------------------------------------------------------------------
interface ddo_out_if;
    logic                       valid;
    logic                       ready;
    logic signed [ddo_pkg::POS_W-1:0] pos_x_out;
    logic signed [ddo_pkg::POS_W-1:0] pos_y_out;
    logic [ddo_pkg::ANG_W-1:0]  heading_out;

    modport source (output valid, output pos_x_out, output pos_y_out, output heading_out,
                    input ready);
    modport sink   (input valid, input pos_x_out, input pos_y_out, input heading_out,
                    output ready);
endinterface

### hdl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences heading update, displacement, CORDIC iterations and position update.
// ----------------------------------------------------------------------------
module ddo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ddo_pkg::t_status i_status,
    output ddo_pkg::t_cmd    o_cmd
);

    ddo_pkg::t_state               r_state;
    ddo_pkg::t_state               n_state;
    logic [ddo_pkg::CIDX_W-1:0]    r_idx;
    logic [ddo_pkg::CIDX_W-1:0]    n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ddo_pkg::S_HEAD;
                end
            end
            ddo_pkg::S_HEAD: begin
                o_cmd.mul_op = ddo_pkg::MUL_HEAD;
                n_state      = ddo_pkg::S_DISP;
            end
            ddo_pkg::S_DISP: begin
                o_cmd.mul_op      = ddo_pkg::MUL_DISP;
                o_cmd.heading_upd = 1'b1;
                n_state           = ddo_pkg::S_CINIT;
            end
            ddo_pkg::S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_idx             = '0;
                n_state           = ddo_pkg::S_CORD;
            end
            ddo_pkg::S_CORD: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.cordic_idx  = r_idx;
                if (r_idx == ddo_pkg::CIDX_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
                    n_state = ddo_pkg::S_CFIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ddo_pkg::S_CFIN: begin
                o_cmd.cordic_fin = 1'b1;
                n_state          = ddo_pkg::S_SIN_LO;
            end
            ddo_pkg::S_SIN_LO: begin
                o_cmd.mul_op = ddo_pkg::MUL_SIN_LO;
                n_state      = ddo_pkg::S_SIN_HI;
            end
            ddo_pkg::S_SIN_HI: begin
                o_cmd.mul_op   = ddo_pkg::MUL_SIN_HI;
                o_cmd.rnd_load = 1'b1;
                n_state        = ddo_pkg::S_COS_LO;
            end
            ddo_pkg::S_COS_LO: begin
                o_cmd.mul_op    = ddo_pkg::MUL_COS_LO;
                o_cmd.term_load = 1'b1;
                n_state         = ddo_pkg::S_COS_HI;
            end
            ddo_pkg::S_COS_HI: begin
                o_cmd.mul_op   = ddo_pkg::MUL_COS_HI;
                o_cmd.rnd_load = 1'b1;
                o_cmd.add_x    = 1'b1;
                n_state        = ddo_pkg::S_TERM_Y;
            end
            ddo_pkg::S_TERM_Y: begin
                o_cmd.term_load = 1'b1;
                n_state         = ddo_pkg::S_ADD_Y;
            end
            ddo_pkg::S_ADD_Y: begin
                o_cmd.add_y = 1'b1;
                n_state     = ddo_pkg::S_DONE;
            end
            ddo_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ddo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ddo_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// Odometry datapath
// Tick deltas, shared multiplier, iterative CORDIC, position accumulators,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ddo_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ddo_pkg::t_cmd                     i_cmd,
    output ddo_pkg::t_status                  o_status,
    input  logic [ddo_pkg::IN_W-1:0]          i_left_count,
    input  logic [ddo_pkg::IN_W-1:0]          i_right_count,
    input  logic                              i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ddo_pkg::POS_W-1:0]  o_pos_x_out,
    output logic signed [ddo_pkg::POS_W-1:0]  o_pos_y_out,
    output logic [ddo_pkg::ANG_W-1:0]         o_heading_out
);

    localparam int CW = ddo_pkg::COUNT_WIDTH;

    logic [ddo_pkg::TL_W-1:0]         r_tick_length;
    logic [ddo_pkg::TPT_W-1:0]        r_turn_per_tick;
    logic [CW-1:0]                    r_prev_left;
    logic [CW-1:0]                    r_prev_right;
    logic signed [CW-1:0]             r_dl;
    logic signed [CW-1:0]             r_dr;
    logic [CW:0]                      r_smag;
    logic                             r_d_neg;
    logic [ddo_pkg::ANG_W-1:0]        r_heading;
    logic [ddo_pkg::POS_W-1:0]        r_pos_x;
    logic [ddo_pkg::POS_W-1:0]        r_pos_y;
    logic [ddo_pkg::PROD_W-1:0]       r_prod;
    logic [ddo_pkg::DMAG_W-1:0]       r_dmag;
    logic signed [ddo_pkg::XY_W-1:0]  r_cx;
    logic signed [ddo_pkg::XY_W-1:0]  r_cy;
    logic signed [ddo_pkg::XY_W-1:0]  r_cz;
    logic                             r_flip;
    logic [ddo_pkg::MUL_B_W-1:0]      r_sin_mag;
    logic [ddo_pkg::MUL_B_W-1:0]      r_cos_mag;
    logic                             r_sin_neg;
    logic                             r_cos_neg;
    logic [ddo_pkg::RND_W-1:0]        r_rnd;
    logic [ddo_pkg::POS_W-1:0]        r_term;
    logic                             r_out_valid;
    logic signed [ddo_pkg::POS_W-1:0] r_out_x;
    logic signed [ddo_pkg::POS_W-1:0] r_out_y;
    logic [ddo_pkg::ANG_W-1:0]        r_out_heading;

    logic [CW-1:0]                    w_left;
    logic [CW-1:0]                    w_right;
    logic signed [CW:0]               w_sum;
    logic signed [CW:0]               w_diff;
    logic [ddo_pkg::MUL_A_W-1:0]      w_mul_a;
    logic [ddo_pkg::MUL_B_W-1:0]      w_mul_b;
    logic [ddo_pkg::PROD_W-1:0]       w_prod;
    logic                             w_flip;
    logic [ddo_pkg::ANG_W-1:0]        w_ang;
    logic [ddo_pkg::ATAN_IDX_W-1:0]   w_k;
    logic signed [ddo_pkg::XY_W-1:0]  w_xs;
    logic signed [ddo_pkg::XY_W-1:0]  w_ys;
    logic signed [ddo_pkg::XY_W-1:0]  w_atan;
    logic [63:0]                      w_rnd_sum;
    logic signed [ddo_pkg::XY_W-1:0]  w_sin_abs;
    logic signed [ddo_pkg::XY_W-1:0]  w_cos_abs;

    assign w_left  = CW'(i_left_count);
    assign w_right = CW'(i_right_count);
    assign w_sum   = (CW + 1)'(r_dl) + (CW + 1)'(r_dr);
    assign w_diff  = (CW + 1)'(r_dl) - (CW + 1)'(r_dr);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_op)
            ddo_pkg::MUL_HEAD: begin
                w_mul_a = {1'b0, 32'(w_diff)};
                w_mul_b = ddo_pkg::MUL_B_W'(r_turn_per_tick);
            end
            ddo_pkg::MUL_DISP: begin
                w_mul_a = ddo_pkg::MUL_A_W'(r_smag);
                w_mul_b = r_tick_length;
            end
            ddo_pkg::MUL_SIN_LO: begin
                w_mul_a = {1'b0, r_dmag[31:0]};
                w_mul_b = r_sin_mag;
            end
            ddo_pkg::MUL_SIN_HI: begin
                w_mul_a = ddo_pkg::MUL_A_W'(r_dmag[ddo_pkg::DMAG_W-1:32]);
                w_mul_b = r_sin_mag;
            end
            ddo_pkg::MUL_COS_LO: begin
                w_mul_a = {1'b0, r_dmag[31:0]};
                w_mul_b = r_cos_mag;
            end
            ddo_pkg::MUL_COS_HI: begin
                w_mul_a = ddo_pkg::MUL_A_W'(r_dmag[ddo_pkg::DMAG_W-1:32]);
                w_mul_b = r_cos_mag;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // fold the half turn around pi onto the range around zero
    assign w_flip    = r_heading[31] ^ r_heading[30];
    assign w_ang     = w_flip ? {~r_heading[31], r_heading[30:0]} : r_heading;
    assign w_k       = ddo_pkg::ATAN_IDX_W'(i_cmd.cordic_idx);
    assign w_xs      = r_cx >>> w_k;
    assign w_ys      = r_cy >>> w_k;
    assign w_atan    = ddo_pkg::XY_W'(ddo_pkg::atan_entry(w_k));
    assign w_rnd_sum = r_prod[63:0] + (64'd1 << 29);
    assign w_sin_abs = r_cy[ddo_pkg::XY_W-1] ? -r_cy : r_cy;
    assign w_cos_abs = r_cx[ddo_pkg::XY_W-1] ? -r_cx : r_cx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_length   <= ddo_pkg::TL_RESET;
            r_turn_per_tick <= ddo_pkg::TPT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddo_pkg::REG_TICK_LENGTH:   r_tick_length   <= i_cfg_data;
                ddo_pkg::REG_TURN_PER_TICK: r_turn_per_tick <= i_cfg_data[ddo_pkg::TPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_heading    <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_prev_left  <= w_left;
                r_prev_right <= w_right;
            end
            if (i_cmd.heading_upd) begin
                r_heading <= r_heading + r_prod[ddo_pkg::ANG_W-1:0];
            end
            if (i_cmd.add_x) begin
                r_pos_x <= (r_d_neg ^ r_sin_neg) ? r_pos_x - r_term : r_pos_x + r_term;
            end
            if (i_cmd.add_y) begin
                r_pos_y <= (r_d_neg ^ r_cos_neg) ? r_pos_y - r_term : r_pos_y + r_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dl <= w_left - r_prev_left;
            r_dr <= w_right - r_prev_right;
        end
        if (i_cmd.mul_op == ddo_pkg::MUL_HEAD) begin
            r_smag  <= w_sum[CW] ? -w_sum : w_sum;
            r_d_neg <= w_sum[CW];
        end
        if (i_cmd.mul_op != ddo_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.cordic_init) begin
            r_dmag <= r_prod[ddo_pkg::DMAG_W:1];
            r_flip <= w_flip;
            r_cx   <= ddo_pkg::CORDIC_INIT_X;
            r_cy   <= '0;
            r_cz   <= ddo_pkg::XY_W'($signed(w_ang));
        end
        if (i_cmd.cordic_step) begin
            if (!r_cz[ddo_pkg::XY_W-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end
        end
        if (i_cmd.cordic_fin) begin
            r_sin_mag <= w_sin_abs[ddo_pkg::MUL_B_W-1:0];
            r_cos_mag <= w_cos_abs[ddo_pkg::MUL_B_W-1:0];
            r_sin_neg <= r_flip ^ r_cy[ddo_pkg::XY_W-1];
            r_cos_neg <= r_flip ^ r_cx[ddo_pkg::XY_W-1];
        end
        if (i_cmd.rnd_load) begin
            r_rnd <= w_rnd_sum[63:30];
        end
        if (i_cmd.term_load) begin
            r_term <= {r_prod[45:0], 2'b00} + ddo_pkg::POS_W'(r_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x       <= r_pos_x;
            r_out_y       <= r_pos_y;
            r_out_heading <= r_heading;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pos_x_out       = r_out_x;
    assign o_pos_y_out       = r_out_y;
    assign o_heading_out     = r_out_heading;

endmodule

### hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead reckoning from wheel encoder samples: heading, then x and y position.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_in      in   left_count, right_count
//  o_out     out  pos_x_out, pos_y_out, heading_out
//  i_cfg_*   in   register index, write data
//
//  A result is loaded once the one-rotation-per-cycle CORDIC and six multiplier
//  passes that follow the acceptance of its sample are through; the next sample
//  can be taken from the cycle after the load.
//  Reset is synchronous; state, counters and positions clear to zero.
//  A stalled result waits in the output register while the next sample
//  is taken; only its final load waits for the register to drain.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ddo_in_if.sink                         i_in,
    ddo_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ddo_pkg::t_cmd    w_cmd;
    ddo_pkg::t_status w_status;
    logic             w_in_ready;

    assign i_in.ready = w_in_ready;

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ddo_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_left_count  (i_in.left_count),
        .i_right_count (i_in.right_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_pos_x_out   (o_out.pos_x_out),
        .o_pos_y_out   (o_out.pos_y_out),
        .o_heading_out (o_out.heading_out)
    );

endmodule

### hdl/ddo_checker.sv
// ----------------------------------------------------------------------------
// Odometry checker
// Port-level checks on sample intake and result delivery.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_macros.svh"

module ddo_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [ddo_pkg::POS_W-1:0]  i_pos_x,
    input logic signed [ddo_pkg::POS_W-1:0]  i_pos_y,
    input logic [ddo_pkg::ANG_W-1:0]         i_heading
);

    `DDO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `DDO_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_heading))
    `DDO_ASSERT_NEXT(a_one_sample, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `DDO_ASSERT_NEXT(a_no_early_beat, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid)
    `DDO_ASSERT_NOW(a_load_while_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x_out),
    .i_pos_y     (o_out.pos_y_out),
    .i_heading   (o_out.heading_out)
);
